FILE: rtl/core/mtc_pkg.sv
// Package for the MIDI to CV converter with highest-note priority.
// Holds the command, result and state types and the MIDI byte constants.
// No dependencies; every other file of the block uses it.
package mtc_pkg;

    // MIDI byte codes
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] DATA_MAX    = 8'h7F;
    localparam logic [7:0] CHAN_NONE   = 8'hFF;

    // Upper nibble of channel status bytes
    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_CONTROL    = 4'hB;
    localparam logic [3:0] KIND_PROGRAM    = 4'hC;
    localparam logic [3:0] KIND_CH_PRESS   = 4'hD;
    localparam logic [3:0] KIND_PITCH_BEND = 4'hE;

    // Controller number and output constants
    localparam logic [6:0] CC_RESET_ALL = 7'h79;
    localparam logic [6:0] NOTE_BASE    = 7'h0B;
    localparam logic [9:0] BEND_FULL    = 10'd1023;
    localparam logic [9:0] BEND_RESET   = 10'd512;
    localparam logic [7:0] CV_RESET     = 8'hFF;

    // Action that one complete channel message asks of the note engine
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_NOTE_ON,
        CMD_NOTE_OFF,
        CMD_RESET_ALL,
        CMD_BEND
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [6:0] note;
        logic [9:0] bend;
    } t_cmd;

    // One result item, as driven toward the output stream
    typedef struct packed {
        logic       gate;
        logic [7:0] pitch_cv;
        logic [9:0] bend_target;
        logic [3:0] held_count;
        logic [6:0] top_note;
    } t_result;

    // Note engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/core/mtc_parser.sv
// MIDI byte parser: status and running status, sysex skipping, data collection.
// Decodes complete messages on the target channel into a note engine command.
// Depends on mtc_pkg.
module mtc_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output mtc_pkg::t_cmd o_cmd
);

    logic [3:0] r_target;
    logic [7:0] r_status, n_status;
    logic [7:0] r_chan, n_chan;
    logic       r_idx, n_idx;
    logic       r_len_two, n_len_two;
    logic [6:0] r_first, n_first;

    logic       act_en;
    logic [6:0] d0;
    logic [6:0] d1;
    logic [9:0] bend_sum;
    logic [9:0] bend_diff;
    logic [12:0] bend_x5;

    // Parse state update for one byte
    always_comb begin
        n_status  = r_status;
        n_chan    = r_chan;
        n_idx     = r_idx;
        n_len_two = r_len_two;
        n_first   = r_first;
        act_en    = 1'b0;
        d0        = i_byte[6:0];
        d1        = 7'd0;
        priority if (r_status == mtc_pkg::SYSEX_START) begin
            if (i_byte == mtc_pkg::SYSEX_END) begin
                n_status = mtc_pkg::SYSEX_END;
            end
        end else if (i_byte > mtc_pkg::SYSEX_START) begin
            n_status  = i_byte;
            n_len_two = 1'b0;
            n_idx     = 1'b0;
        end else if (i_byte == mtc_pkg::SYSEX_START) begin
            n_status = mtc_pkg::SYSEX_START;
        end else if (i_byte > mtc_pkg::DATA_MAX) begin
            n_status  = i_byte;
            n_chan    = {4'h0, i_byte[3:0]};
            n_len_two = !(i_byte[7:4] == mtc_pkg::KIND_PROGRAM ||
                          i_byte[7:4] == mtc_pkg::KIND_CH_PRESS);
            n_idx     = 1'b0;
        end else if (!r_idx) begin
            n_first = i_byte[6:0];
            if (!r_len_two) begin
                act_en = (r_status < mtc_pkg::SYSEX_START);
            end else begin
                n_idx = 1'b1;
            end
        end else begin
            n_idx  = 1'b0;
            act_en = (r_status < mtc_pkg::SYSEX_START);
            d0     = r_first;
            d1     = i_byte[6:0];
        end
    end

    // Pitch bend scaling: (1023 - (lsb/16 + msb*8)) * 5 / 32
    always_comb begin
        bend_sum  = {7'd0, d0[6:4]} + {d1, 3'd0};
        bend_diff = mtc_pkg::BEND_FULL - bend_sum;
        bend_x5   = {1'b0, bend_diff, 2'b00} + {3'b000, bend_diff};
    end

    // Message decode into an engine command
    always_comb begin
        o_cmd.kind = mtc_pkg::CMD_NONE;
        o_cmd.note = d0;
        o_cmd.bend = {2'b00, bend_x5[12:5]};
        if (act_en && r_chan == {4'h0, r_target}) begin
            unique case (r_status[7:4])
                mtc_pkg::KIND_NOTE_OFF: begin
                    o_cmd.kind = mtc_pkg::CMD_NOTE_OFF;
                end
                mtc_pkg::KIND_NOTE_ON: begin
                    o_cmd.kind = (d1 == 7'd0) ? mtc_pkg::CMD_NOTE_OFF
                                              : mtc_pkg::CMD_NOTE_ON;
                end
                mtc_pkg::KIND_CONTROL: begin
                    if (d0 == mtc_pkg::CC_RESET_ALL) begin
                        o_cmd.kind = mtc_pkg::CMD_RESET_ALL;
                    end
                end
                mtc_pkg::KIND_PITCH_BEND: begin
                    o_cmd.kind = mtc_pkg::CMD_BEND;
                end
                default: begin
                    o_cmd.kind = mtc_pkg::CMD_NONE;
                end
            endcase
        end
    end

    // Parse registers and the channel setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= 4'd0;
            r_status  <= 8'd0;
            r_chan    <= mtc_pkg::CHAN_NONE;
            r_idx     <= 1'b0;
            r_len_two <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_status  <= n_status;
                r_chan    <= n_chan;
                r_idx     <= n_idx;
                r_len_two <= n_len_two;
                r_first   <= n_first;
            end
        end
    end

endmodule

FILE: rtl/core/mtc_note_engine.sv
// Note engine: held-note table sorted descending, walked one entry per cycle
// by a small sequencer with a carry register, plus gate, CV and bend state.
// Depends on mtc_pkg.
module mtc_note_engine #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mtc_pkg::t_cmd    i_cmd,
    output logic             o_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output mtc_pkg::t_result o_result
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] SAT_MAX = CNT_W'(15);

    mtc_pkg::t_state r_state, n_state;

    logic [6:0]       r_table [TABLE_DEPTH];
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [6:0]       r_carry, n_carry;
    logic             r_flag, n_flag;
    logic             r_press, n_press;
    logic [6:0]       r_top, n_top;
    logic             r_gate, n_gate;
    logic [7:0]       r_cv, n_cv;
    logic [9:0]       r_bend, n_bend;
    logic             r_out_valid, n_out_valid;
    mtc_pkg::t_result r_result, n_result;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [6:0]       wr_data;
    logic [6:0]       entry;
    logic             at_end;
    logic             out_free;

    // Pitch PWM value from a note: twice (note - 11), minimum 2
    function automatic logic [7:0] cv_of(input logic [6:0] note);
        logic [6:0] v;
        v = (note > mtc_pkg::NOTE_BASE) ? (note - mtc_pkg::NOTE_BASE) : 7'd1;
        return {v, 1'b0};
    endfunction

    assign entry    = r_table[r_idx[IDX_W-1:0]];
    assign at_end   = (r_idx == r_count);
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer: next state, table write and note state
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_carry     = r_carry;
        n_flag      = r_flag;
        n_press     = r_press;
        n_top       = r_top;
        n_gate      = r_gate;
        n_cv        = r_cv;
        n_bend      = r_bend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_result    = r_result;
        wr_en       = 1'b0;
        wr_addr     = r_idx[IDX_W-1:0];
        wr_data     = r_carry;
        o_ready     = 1'b0;
        unique case (r_state)
            mtc_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_idx   = '0;
                    n_flag  = 1'b0;
                    n_carry = i_cmd.note;
                    n_press = (i_cmd.kind == mtc_pkg::CMD_NOTE_ON);
                    n_state = mtc_pkg::ST_FINISH;
                    unique case (i_cmd.kind)
                        mtc_pkg::CMD_NOTE_ON, mtc_pkg::CMD_NOTE_OFF: begin
                            n_state = mtc_pkg::ST_WALK;
                        end
                        mtc_pkg::CMD_RESET_ALL: begin
                            n_bend  = mtc_pkg::BEND_RESET;
                            n_count = '0;
                            n_gate  = 1'b0;
                        end
                        mtc_pkg::CMD_BEND: begin
                            n_bend = i_cmd.bend;
                        end
                        default: begin
                            n_state = mtc_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            mtc_pkg::ST_WALK: begin
                if (r_press) begin
                    // Insertion walk: the carry holds the note being pushed down
                    priority if (at_end) begin
                        if (r_idx != DEPTH_C) begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                            if (r_idx == '0) begin
                                n_top = r_carry;
                            end
                        end
                        n_cv    = cv_of(n_top);
                        n_gate  = 1'b1;
                        n_state = mtc_pkg::ST_FINISH;
                    end else if (!r_flag && entry == r_carry) begin
                        n_state = mtc_pkg::ST_FINISH;
                    end else if (r_flag || r_carry > entry) begin
                        wr_en   = 1'b1;
                        n_carry = entry;
                        n_flag  = 1'b1;
                        if (r_idx == '0) begin
                            n_top = r_carry;
                        end
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    // Removal walk: entries after the match move up by one
                    if (at_end) begin
                        if (r_flag) begin
                            n_count = r_count - 1'b1;
                            if (n_count == '0) begin
                                n_gate = 1'b0;
                            end else begin
                                n_cv = cv_of(r_top);
                            end
                        end
                        n_state = mtc_pkg::ST_FINISH;
                    end else begin
                        if (r_flag) begin
                            wr_en   = 1'b1;
                            wr_addr = IDX_W'(r_idx - 1'b1);
                            wr_data = entry;
                            if (r_idx == CNT_W'(1)) begin
                                n_top = entry;
                            end
                        end
                        if (entry == r_carry) begin
                            n_flag = 1'b1;
                        end
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            mtc_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_result.gate        = r_gate;
                    n_result.pitch_cv    = r_cv;
                    n_result.bend_target = r_bend;
                    n_result.held_count  = (r_count > SAT_MAX) ? 4'd15 : 4'(r_count);
                    n_result.top_note    = r_top;
                    n_state              = mtc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mtc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and note state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtc_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_flag      <= 1'b0;
            r_press     <= 1'b0;
            r_top       <= 7'd0;
            r_gate      <= 1'b0;
            r_cv        <= mtc_pkg::CV_RESET;
            r_bend      <= mtc_pkg::BEND_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_flag      <= n_flag;
            r_press     <= n_press;
            r_top       <= n_top;
            r_gate      <= n_gate;
            r_cv        <= n_cv;
            r_bend      <= n_bend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_carry  <= n_carry;
        r_result <= n_result;
    end

    // Note table: one write port, no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

FILE: rtl/core/midi_to_cv_highest_note.sv
// MIDI to CV converter, highest-note priority. One result per MIDI byte.
// A byte other than a note message goes straight to the finish state; a note
// message first walks the held-note table one entry per cycle, over at most
// TABLE_DEPTH entries. The finish state waits for a free output register. The next byte is taken
// once the previous result sits in the output register. Synchronous active-low
// reset restores the parser and note state; the note table keeps no reset.
module midi_to_cv_highest_note #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: target_channel
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [0] gate, [8:1] pitch_cv, [18:9] bend_target,
                                        // [22:19] held_count, [29:23] top_note, [31:30] 0
);

    mtc_pkg::t_cmd    cmd;
    mtc_pkg::t_result result;
    logic             accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Byte parser and message decode
    mtc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .o_cmd       (cmd)
    );

    // Held-note table sequencer and output register
    mtc_note_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_cmd       (cmd),
        .o_ready     (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (result)
    );

    // Output packing, first field in the lowest bits
    assign m_axis_tdata = {2'b00, result.top_note, result.held_count,
                           result.bend_target, result.pitch_cv, result.gate};

endmodule
